@@ hw/rtl/ilpc_pkg.sv @@
// Shared types and constants for the indicator LED priority controller.
// No dependencies; used by ilpc_cfg, ilpc_core and the top level.
`timescale 1ns / 1ps

package ilpc_pkg;

	localparam int LEVEL_W = 7;
	localparam int STEP_W = 6;
	localparam int IVL_W = 10;
	localparam int HOLD_W = 16;
	localparam int CMD_W = 2;
	localparam int IND_W = 8;
	localparam int IDX_W = 3;
	localparam int DATA_W = 16;
	localparam int CAPS_BIT = 1;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [IDX_W-1:0] REG_BOOT_LEVEL = 3'd0;
	localparam logic [IDX_W-1:0] REG_LEVEL_FLOOR = 3'd1;
	localparam logic [IDX_W-1:0] REG_ANIM_TOP = 3'd2;
	localparam logic [IDX_W-1:0] REG_ANIM_LOW = 3'd3;
	localparam logic [IDX_W-1:0] REG_ANIM_STEP = 3'd4;
	localparam logic [IDX_W-1:0] REG_ANIM_IVL = 3'd5;
	localparam logic [IDX_W-1:0] REG_BOOT_HOLD = 3'd6;
	localparam logic [IDX_W-1:0] REG_TOUCH_HOLD = 3'd7;

	localparam logic [LEVEL_W-1:0] RST_BOOT_LEVEL = 7'd40;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_FLOOR = 7'd10;
	localparam logic [LEVEL_W-1:0] RST_ANIM_TOP = 7'd100;
	localparam logic [LEVEL_W-1:0] RST_ANIM_LOW = 7'd20;
	localparam logic [STEP_W-1:0] RST_ANIM_STEP = 6'd5;
	localparam logic [IVL_W-1:0] RST_ANIM_IVL = 10'd20;
	localparam logic [HOLD_W-1:0] RST_BOOT_HOLD = 16'd3000;
	localparam logic [HOLD_W-1:0] RST_TOUCH_HOLD = 16'd5000;
	localparam logic [LEVEL_W-1:0] RST_REMEMBERED = 7'd100;

	typedef struct packed {
		logic [LEVEL_W-1:0] boot_level;
		logic [LEVEL_W-1:0] level_floor;
		logic [LEVEL_W-1:0] anim_top;
		logic [LEVEL_W-1:0] anim_low;
		logic [STEP_W-1:0] anim_step;
		logic [IVL_W-1:0] anim_interval_ms;
		logic [HOLD_W-1:0] boot_hold_ms;
		logic [HOLD_W-1:0] touch_hold_ms;
	} cfg_t;

endpackage

@@ hw/rtl/ilpc_cfg.sv @@
// Configuration register file for the indicator LED priority controller.
// Depends on ilpc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ilpc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ilpc_pkg::IDX_W-1:0]  wr_index,
	input  logic [ilpc_pkg::DATA_W-1:0] wr_data,
	output ilpc_pkg::cfg_t            cfg
);

	ilpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_level <= ilpc_pkg::RST_BOOT_LEVEL;
			cfg_q.level_floor <= ilpc_pkg::RST_LEVEL_FLOOR;
			cfg_q.anim_top <= ilpc_pkg::RST_ANIM_TOP;
			cfg_q.anim_low <= ilpc_pkg::RST_ANIM_LOW;
			cfg_q.anim_step <= ilpc_pkg::RST_ANIM_STEP;
			cfg_q.anim_interval_ms <= ilpc_pkg::RST_ANIM_IVL;
			cfg_q.boot_hold_ms <= ilpc_pkg::RST_BOOT_HOLD;
			cfg_q.touch_hold_ms <= ilpc_pkg::RST_TOUCH_HOLD;
		end else if (wr_en) begin
			unique case (wr_index)
				ilpc_pkg::REG_BOOT_LEVEL: cfg_q.boot_level <= wr_data[ilpc_pkg::LEVEL_W-1:0];
				ilpc_pkg::REG_LEVEL_FLOOR: cfg_q.level_floor <= wr_data[ilpc_pkg::LEVEL_W-1:0];
				ilpc_pkg::REG_ANIM_TOP: cfg_q.anim_top <= wr_data[ilpc_pkg::LEVEL_W-1:0];
				ilpc_pkg::REG_ANIM_LOW: cfg_q.anim_low <= wr_data[ilpc_pkg::LEVEL_W-1:0];
				ilpc_pkg::REG_ANIM_STEP: cfg_q.anim_step <= wr_data[ilpc_pkg::STEP_W-1:0];
				ilpc_pkg::REG_ANIM_IVL: cfg_q.anim_interval_ms <= wr_data[ilpc_pkg::IVL_W-1:0];
				ilpc_pkg::REG_BOOT_HOLD: cfg_q.boot_hold_ms <= wr_data;
				ilpc_pkg::REG_TOUCH_HOLD: cfg_q.touch_hold_ms <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/ilpc_core.sv @@
// Controller state and next-state logic: holds, breathing ramp, priority pick.
// Depends on ilpc_pkg for command codes, reset values and cfg_t.
`timescale 1ns / 1ps

module ilpc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_en,
	input  logic [ilpc_pkg::CMD_W-1:0]   cmd,
	input  logic [ilpc_pkg::IND_W-1:0]   indicators,
	input  logic [ilpc_pkg::LEVEL_W-1:0] backlight_level,
	input  ilpc_pkg::cfg_t              cfg,
	output logic                        wrote,
	output logic [ilpc_pkg::LEVEL_W-1:0] level
);

	logic caps_on_q, boot_on_q, touch_on_q, ramp_rising_q;
	logic [ilpc_pkg::LEVEL_W-1:0] ramp_level_q, remembered_q;
	logic [ilpc_pkg::HOLD_W-1:0] boot_count_q, touch_count_q;
	logic [ilpc_pkg::IVL_W-1:0] ramp_count_q;

	logic caps_d, boot_d, touch_d, rising_d;
	logic [ilpc_pkg::LEVEL_W-1:0] ramp_d, rem_d;
	logic [ilpc_pkg::HOLD_W-1:0] boot_cnt_d, touch_cnt_d;
	logic [ilpc_pkg::IVL_W-1:0] ramp_cnt_d;

	// remembered level refreshed from a nonzero backlight
	logic [ilpc_pkg::LEVEL_W-1:0] rem_fresh;
	assign rem_fresh = (backlight_level == '0) ? remembered_q :
		((backlight_level > cfg.level_floor) ? backlight_level : cfg.level_floor);

	always_comb begin
		logic new_caps;
		logic do_step;
		logic [ilpc_pkg::LEVEL_W-1:0] base;
		logic [ilpc_pkg::LEVEL_W:0] up;
		logic [ilpc_pkg::LEVEL_W-1:0] down;
		logic [ilpc_pkg::LEVEL_W-1:0] stepped;
		logic stepped_rising;
		logic base_rising;

		caps_d = caps_on_q;
		boot_d = boot_on_q;
		touch_d = touch_on_q;
		rising_d = ramp_rising_q;
		ramp_d = ramp_level_q;
		rem_d = remembered_q;
		boot_cnt_d = boot_count_q;
		touch_cnt_d = touch_count_q;
		ramp_cnt_d = ramp_count_q;
		wrote = 1'b0;
		level = '0;

		new_caps = indicators[ilpc_pkg::CAPS_BIT];
		do_step = 1'b0;

		// ramp step from either the held ramp or a fresh restart
		base = (cmd == ilpc_pkg::CMD_REPORT) ? cfg.level_floor : ramp_level_q;
		base_rising = (cmd == ilpc_pkg::CMD_REPORT) ? 1'b1 : ramp_rising_q;
		up = {1'b0, base} + {2'b00, cfg.anim_step};
		down = (base > {1'b0, cfg.anim_step}) ? (base - {1'b0, cfg.anim_step}) : '0;
		if (base_rising) begin
			if (up >= {1'b0, cfg.anim_top}) begin
				stepped = cfg.anim_top;
				stepped_rising = 1'b0;
			end else begin
				stepped = up[ilpc_pkg::LEVEL_W-1:0];
				stepped_rising = 1'b1;
			end
		end else begin
			if (down <= cfg.anim_low) begin
				stepped = cfg.anim_low;
				stepped_rising = 1'b1;
			end else begin
				stepped = down;
				stepped_rising = 1'b0;
			end
		end

		unique case (cmd)
			ilpc_pkg::CMD_TICK: begin
				if (boot_on_q) begin
					if (boot_count_q > 16'd1) begin
						boot_cnt_d = boot_count_q - 16'd1;
					end else begin
						boot_cnt_d = '0;
						boot_d = 1'b0;
						if (!caps_on_q && !touch_on_q) begin
							wrote = 1'b1;
							level = '0;
						end
					end
				end
				if (touch_on_q) begin
					if (touch_count_q > 16'd1) begin
						touch_cnt_d = touch_count_q - 16'd1;
					end else begin
						touch_cnt_d = '0;
						touch_d = 1'b0;
						if (!caps_on_q && !boot_d) begin
							wrote = 1'b1;
							level = '0;
						end else if (boot_d && !caps_on_q) begin
							wrote = 1'b1;
							level = cfg.boot_level;
						end
					end
				end
				if (caps_on_q) begin
					if (ramp_count_q > 10'd1) begin
						ramp_cnt_d = ramp_count_q - 10'd1;
					end else begin
						do_step = 1'b1;
					end
				end
			end
			ilpc_pkg::CMD_TOUCH: begin
				touch_d = 1'b1;
				touch_cnt_d = cfg.touch_hold_ms;
				if (!caps_on_q) begin
					rem_d = rem_fresh;
					wrote = 1'b1;
					level = rem_fresh;
				end
			end
			ilpc_pkg::CMD_REPORT: begin
				if (new_caps != caps_on_q) begin
					caps_d = new_caps;
					wrote = 1'b1;
					if (new_caps) begin
						do_step = 1'b1;
					end else if (touch_on_q) begin
						rem_d = rem_fresh;
						level = rem_fresh;
					end else if (boot_on_q) begin
						level = cfg.boot_level;
					end else begin
						level = '0;
					end
				end
			end
			default: begin
				wrote = 1'b0;
			end
		endcase

		if (do_step) begin
			ramp_d = stepped;
			rising_d = stepped_rising;
			ramp_cnt_d = cfg.anim_interval_ms;
			wrote = 1'b1;
			level = stepped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_on_q <= 1'b0;
			boot_on_q <= 1'b1;
			touch_on_q <= 1'b0;
			ramp_rising_q <= 1'b1;
			ramp_level_q <= ilpc_pkg::RST_LEVEL_FLOOR;
			remembered_q <= ilpc_pkg::RST_REMEMBERED;
			boot_count_q <= ilpc_pkg::RST_BOOT_HOLD;
			touch_count_q <= '0;
			ramp_count_q <= '0;
		end else if (item_en) begin
			caps_on_q <= caps_d;
			boot_on_q <= boot_d;
			touch_on_q <= touch_d;
			ramp_rising_q <= rising_d;
			ramp_level_q <= ramp_d;
			remembered_q <= rem_d;
			boot_count_q <= boot_cnt_d;
			touch_count_q <= touch_cnt_d;
			ramp_count_q <= ramp_cnt_d;
		end
	end

endmodule

@@ hw/rtl/indicator_led_priority_controller_top.sv @@
// Indicator LED priority controller: input register, state logic, output register.
// Items pass input and result registers; one item per cycle unless out_ready stalls,
// set by the single state update pass between the input and result registers.
// Reset: asynchronous, active low; boot hold starts, no level is emitted at reset.
// Depends on ilpc_pkg, ilpc_cfg and ilpc_core.
`timescale 1ns / 1ps

module indicator_led_priority_controller_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ilpc_pkg::CMD_W-1:0]   cmd,
	input  logic [ilpc_pkg::IND_W-1:0]   indicators,
	input  logic [ilpc_pkg::LEVEL_W-1:0] backlight_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ilpc_pkg::LEVEL_W-1:0] led_level,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ilpc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ilpc_pkg::DATA_W-1:0]  cfg_data
);

	ilpc_pkg::cfg_t cfg;

	logic valid_s1;
	logic [ilpc_pkg::CMD_W-1:0] cmd_s1;
	logic [ilpc_pkg::IND_W-1:0] ind_s1;
	logic [ilpc_pkg::LEVEL_W-1:0] bl_s1;

	logic out_valid_q;
	logic [ilpc_pkg::LEVEL_W-1:0] led_level_q;

	logic advance;
	logic wrote;
	logic [ilpc_pkg::LEVEL_W-1:0] level;

	assign cfg_ready = 1'b1;

	// advance stage one whenever the result register can take its transaction
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	ilpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ilpc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_en         (valid_s1 && advance),
		.cmd             (cmd_s1),
		.indicators      (ind_s1),
		.backlight_level (bl_s1),
		.cfg             (cfg),
		.wrote           (wrote),
		.level           (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
			ind_s1 <= indicators;
			bl_s1 <= backlight_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && wrote;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && wrote) begin
			led_level_q <= level;
		end
	end

	assign out_valid = out_valid_q;
	assign led_level = led_level_q;

endmodule

@@ tb/indicator_led_priority_controller_top_tb.sv @@
// Self-checking bench for indicator_led_priority_controller_top: random valid/ready traffic,
// register phases between drains, and an in-bench predictor of every LED level written.
// Depends on ilpc_pkg and the RTL top level.
`timescale 1ns / 1ps

module indicator_led_priority_controller_top_tb;

	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 110;
	localparam int BOOT_RUN_ITEMS = 600;
	localparam int NUM_REGS = 8;
	localparam logic [ilpc_pkg::IND_W-1:0] CAPS_MASK =
		ilpc_pkg::IND_W'(1) << ilpc_pkg::CAPS_BIT;

	typedef enum logic [1:0] {STIM_ITEM, STIM_REG, STIM_DRAIN} stim_kind_t;
	typedef enum logic [1:0] {SET_MIN, SET_MAX, SET_TYPICAL, SET_WILD} reg_mode_t;

	typedef struct {
		stim_kind_t kind;
		logic [ilpc_pkg::CMD_W-1:0] cmd;
		logic [ilpc_pkg::IND_W-1:0] ind;
		logic [ilpc_pkg::LEVEL_W-1:0] bl;
		logic [ilpc_pkg::IDX_W-1:0] idx;
		logic [ilpc_pkg::DATA_W-1:0] data;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ilpc_pkg::CMD_W-1:0] cmd = ilpc_pkg::CMD_TICK;
	logic [ilpc_pkg::IND_W-1:0] indicators = '0;
	logic [ilpc_pkg::LEVEL_W-1:0] backlight_level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ilpc_pkg::LEVEL_W-1:0] led_level;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ilpc_pkg::IDX_W-1:0] cfg_index = ilpc_pkg::REG_BOOT_LEVEL;
	logic [ilpc_pkg::DATA_W-1:0] cfg_data = '0;

	stim_t stim_q[$];
	logic [ilpc_pkg::LEVEL_W-1:0] pending_levels[$];

	ilpc_pkg::cfg_t shadow_cfg;
	logic p_caps, p_boot, p_touch, p_rising;
	logic [ilpc_pkg::LEVEL_W-1:0] p_ramp, p_remembered;
	logic [ilpc_pkg::HOLD_W-1:0] p_boot_cnt, p_touch_cnt;
	logic [ilpc_pkg::IVL_W-1:0] p_ramp_cnt;

	int items_sent = 0;
	int reg_writes = 0;
	int levels_checked = 0;
	int fail_count = 0;
	int unsigned gap_left, settle_left, stall_left;
	logic drv_burst, mon_burst;

	indicator_led_priority_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.indicators(indicators),
		.backlight_level(backlight_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_level(led_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	function automatic logic [ilpc_pkg::LEVEL_W-1:0] recall_backlight(
			input logic [ilpc_pkg::LEVEL_W-1:0] bl);
		if (bl != 0)
			p_remembered = (bl > shadow_cfg.level_floor) ? bl : shadow_cfg.level_floor;
		return p_remembered;
	endfunction

	function automatic logic [ilpc_pkg::LEVEL_W-1:0] breathe_step();
		int unsigned lvl, stp, v;
		lvl = 32'(p_ramp);
		stp = 32'(shadow_cfg.anim_step);
		if (p_rising) begin
			v = lvl + stp;
			if (v >= 32'(shadow_cfg.anim_top)) begin
				v = 32'(shadow_cfg.anim_top);
				p_rising = 1'b0;
			end
		end else begin
			v = (lvl > stp) ? lvl - stp : 0;
			if (v <= 32'(shadow_cfg.anim_low)) begin
				v = 32'(shadow_cfg.anim_low);
				p_rising = 1'b1;
			end
		end
		p_ramp = v[ilpc_pkg::LEVEL_W-1:0];
		p_ramp_cnt = shadow_cfg.anim_interval_ms;
		return p_ramp;
	endfunction

	function automatic void predict_led_level(input logic [ilpc_pkg::CMD_W-1:0] c,
			input logic [ilpc_pkg::IND_W-1:0] ind, input logic [ilpc_pkg::LEVEL_W-1:0] bl);
		logic wrote;
		logic caps_req;
		logic [ilpc_pkg::LEVEL_W-1:0] lvl;
		wrote = 1'b0;
		lvl = '0;
		caps_req = ind[ilpc_pkg::CAPS_BIT];
		case (c)
			ilpc_pkg::CMD_TICK: begin
				if (p_boot) begin
					if (p_boot_cnt > 1) begin
						p_boot_cnt--;
					end else begin
						p_boot_cnt = '0;
						p_boot = 1'b0;
						if (!p_caps && !p_touch) begin
							lvl = '0;
							wrote = 1'b1;
						end
					end
				end
				if (p_touch) begin
					if (p_touch_cnt > 1) begin
						p_touch_cnt--;
					end else begin
						p_touch_cnt = '0;
						p_touch = 1'b0;
						if (!p_caps && !p_boot) begin
							lvl = '0;
							wrote = 1'b1;
						end else if (p_boot && !p_caps) begin
							lvl = shadow_cfg.boot_level;
							wrote = 1'b1;
						end
					end
				end
				if (p_caps) begin
					if (p_ramp_cnt > 1) begin
						p_ramp_cnt--;
					end else begin
						lvl = breathe_step();
						wrote = 1'b1;
					end
				end
			end
			ilpc_pkg::CMD_TOUCH: begin
				p_touch = 1'b1;
				if (!p_caps) begin
					lvl = recall_backlight(bl);
					wrote = 1'b1;
				end
				p_touch_cnt = shadow_cfg.touch_hold_ms;
			end
			ilpc_pkg::CMD_REPORT: begin
				if (caps_req != p_caps) begin
					p_caps = caps_req;
					wrote = 1'b1;
					if (caps_req) begin
						p_ramp = shadow_cfg.level_floor;
						p_rising = 1'b1;
						lvl = breathe_step();
					end else if (p_touch) begin
						lvl = recall_backlight(bl);
					end else if (p_boot) begin
						lvl = shadow_cfg.boot_level;
					end else begin
						lvl = '0;
					end
				end
			end
			default: begin
			end
		endcase
		if (wrote)
			pending_levels.push_back(lvl);
	endfunction

	function automatic void write_shadow_reg(input logic [ilpc_pkg::IDX_W-1:0] idx,
			input logic [ilpc_pkg::DATA_W-1:0] data);
		case (idx)
			ilpc_pkg::REG_BOOT_LEVEL:
				shadow_cfg.boot_level = data[ilpc_pkg::LEVEL_W-1:0];
			ilpc_pkg::REG_LEVEL_FLOOR:
				shadow_cfg.level_floor = data[ilpc_pkg::LEVEL_W-1:0];
			ilpc_pkg::REG_ANIM_TOP:
				shadow_cfg.anim_top = data[ilpc_pkg::LEVEL_W-1:0];
			ilpc_pkg::REG_ANIM_LOW:
				shadow_cfg.anim_low = data[ilpc_pkg::LEVEL_W-1:0];
			ilpc_pkg::REG_ANIM_STEP:
				shadow_cfg.anim_step = data[ilpc_pkg::STEP_W-1:0];
			ilpc_pkg::REG_ANIM_IVL:
				shadow_cfg.anim_interval_ms = data[ilpc_pkg::IVL_W-1:0];
			ilpc_pkg::REG_BOOT_HOLD:
				shadow_cfg.boot_hold_ms = data[ilpc_pkg::HOLD_W-1:0];
			default:
				shadow_cfg.touch_hold_ms = data[ilpc_pkg::HOLD_W-1:0];
		endcase
	endfunction

	function automatic void push_item(input logic [ilpc_pkg::CMD_W-1:0] c,
			input logic [ilpc_pkg::IND_W-1:0] ind, input logic [ilpc_pkg::LEVEL_W-1:0] bl);
		stim_t s;
		s.kind = STIM_ITEM;
		s.cmd = c;
		s.ind = ind;
		s.bl = bl;
		s.idx = ilpc_pkg::REG_BOOT_LEVEL;
		s.data = '0;
		stim_q.push_back(s);
	endfunction

	function automatic void push_reg(input logic [ilpc_pkg::IDX_W-1:0] idx,
			input logic [ilpc_pkg::DATA_W-1:0] data);
		stim_t s;
		s.kind = STIM_REG;
		s.cmd = ilpc_pkg::CMD_TICK;
		s.ind = '0;
		s.bl = '0;
		s.idx = idx;
		s.data = data;
		stim_q.push_back(s);
	endfunction

	function automatic void push_drain();
		stim_t s;
		s.kind = STIM_DRAIN;
		s.cmd = ilpc_pkg::CMD_TICK;
		s.ind = '0;
		s.bl = '0;
		s.idx = ilpc_pkg::REG_BOOT_LEVEL;
		s.data = '0;
		stim_q.push_back(s);
	endfunction

	function automatic void push_random_item();
		int unsigned r, rb;
		logic [ilpc_pkg::CMD_W-1:0] c;
		logic [ilpc_pkg::LEVEL_W-1:0] bl;
		r = $urandom_range(0, 99);
		rb = $urandom_range(0, 99);
		if (r < 68)
			c = ilpc_pkg::CMD_TICK;
		else if (r < 80)
			c = ilpc_pkg::CMD_TOUCH;
		else if (r < 97)
			c = ilpc_pkg::CMD_REPORT;
		else
			c = ilpc_pkg::CMD_UNUSED;
		if (rb < 20)
			bl = '0;
		else if (rb < 90)
			bl = ilpc_pkg::LEVEL_W'($urandom_range(0, 100));
		else
			bl = ilpc_pkg::LEVEL_W'($urandom_range(101, 127));
		push_item(c, ilpc_pkg::IND_W'($urandom_range(0, 255)), bl);
	endfunction

	function automatic logic [ilpc_pkg::DATA_W-1:0] pick_reg_value(
			input logic [ilpc_pkg::IDX_W-1:0] idx, input reg_mode_t mode);
		int unsigned lo, hi;
		logic is_hold;
		is_hold = 1'b0;
		case (idx)
			ilpc_pkg::REG_ANIM_TOP: begin
				lo = 1;
				hi = 100;
			end
			ilpc_pkg::REG_ANIM_STEP: begin
				lo = 1;
				hi = 50;
			end
			ilpc_pkg::REG_ANIM_IVL: begin
				lo = 1;
				hi = 1000;
			end
			ilpc_pkg::REG_BOOT_HOLD, ilpc_pkg::REG_TOUCH_HOLD: begin
				lo = 0;
				hi = 65535;
				is_hold = 1'b1;
			end
			default: begin
				lo = 0;
				hi = 100;
			end
		endcase
		case (mode)
			SET_MIN: return ilpc_pkg::DATA_W'(lo);
			SET_MAX: return ilpc_pkg::DATA_W'(hi);
			SET_WILD: return ilpc_pkg::DATA_W'($urandom_range(0, 65535));
			default: begin
				if (is_hold)
					return ilpc_pkg::DATA_W'($urandom_range(0, 40));
				if (idx == ilpc_pkg::REG_ANIM_IVL)
					return ilpc_pkg::DATA_W'($urandom_range(1, 30));
				return ilpc_pkg::DATA_W'($urandom_range(lo, hi));
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		logic in_hold;
		logic reg_hold;
		stim_t head;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			cmd <= ilpc_pkg::CMD_TICK;
			indicators <= '0;
			backlight_level <= '0;
			cfg_index <= ilpc_pkg::REG_BOOT_LEVEL;
			cfg_data <= '0;
			gap_left = 0;
			settle_left = SETTLE_CYCLES;
			drv_burst = 1'b0;
		end else begin
			in_hold = in_valid;
			reg_hold = cfg_valid;
			if (in_valid && in_ready) begin
				predict_led_level(cmd, indicators, backlight_level);
				items_sent++;
				in_hold = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				write_shadow_reg(cfg_index, cfg_data);
				reg_writes++;
				reg_hold = 1'b0;
			end
			if (!in_hold && !reg_hold && stim_q.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (stim_q[0].kind == STIM_ITEM) begin
					head = stim_q.pop_front();
					cmd <= head.cmd;
					indicators <= head.ind;
					backlight_level <= head.bl;
					in_hold = 1'b1;
					if ($urandom_range(0, 149) == 0)
						drv_burst = !drv_burst;
					gap_left = drv_burst ? 0 : pick_gap();
				end else if (pending_levels.size() != 0) begin
					settle_left = SETTLE_CYCLES;
				end else if (settle_left != 0) begin
					settle_left--;
				end else begin
					head = stim_q.pop_front();
					settle_left = SETTLE_CYCLES;
					if (head.kind == STIM_REG) begin
						cfg_index <= head.idx;
						cfg_data <= head.data;
						reg_hold = 1'b1;
					end
				end
			end
			in_valid <= in_hold;
			cfg_valid <= reg_hold;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [ilpc_pkg::LEVEL_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			mon_burst = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_levels.size() == 0) begin
					$error("led_level: unexpected transaction, expected none, actual %0d",
						led_level);
					fail_count++;
				end else begin
					want = pending_levels.pop_front();
					levels_checked++;
					if (led_level !== want) begin
						$error("led_level: expected %0d, actual %0d", want, led_level);
						fail_count++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				mon_burst = !mon_burst;
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!mon_burst)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#8_000_000;
		$error("timeout: %0d LED levels still expected", pending_levels.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		reg_mode_t mode;
		int unsigned drain_at;
		shadow_cfg.boot_level = ilpc_pkg::RST_BOOT_LEVEL;
		shadow_cfg.level_floor = ilpc_pkg::RST_LEVEL_FLOOR;
		shadow_cfg.anim_top = ilpc_pkg::RST_ANIM_TOP;
		shadow_cfg.anim_low = ilpc_pkg::RST_ANIM_LOW;
		shadow_cfg.anim_step = ilpc_pkg::RST_ANIM_STEP;
		shadow_cfg.anim_interval_ms = ilpc_pkg::RST_ANIM_IVL;
		shadow_cfg.boot_hold_ms = ilpc_pkg::RST_BOOT_HOLD;
		shadow_cfg.touch_hold_ms = ilpc_pkg::RST_TOUCH_HOLD;
		p_caps = 1'b0;
		p_boot = 1'b1;
		p_touch = 1'b0;
		p_rising = 1'b1;
		p_ramp = ilpc_pkg::RST_LEVEL_FLOOR;
		p_remembered = ilpc_pkg::RST_REMEMBERED;
		p_boot_cnt = ilpc_pkg::RST_BOOT_HOLD;
		p_touch_cnt = '0;
		p_ramp_cnt = '0;

		// reset values: remembered level, floor clamp, caps toggles, ignored items
		push_item(ilpc_pkg::CMD_TICK, '0, '0);
		push_item(ilpc_pkg::CMD_TOUCH, '0, '0);
		push_item(ilpc_pkg::CMD_TOUCH, '1, '1);
		push_item(ilpc_pkg::CMD_TOUCH, '0, 7'd3);
		push_item(ilpc_pkg::CMD_REPORT, CAPS_MASK, '0);
		push_item(ilpc_pkg::CMD_REPORT, '1, '1);
		push_item(ilpc_pkg::CMD_TOUCH, '0, 7'd50);
		push_item(ilpc_pkg::CMD_UNUSED, '1, '1);
		push_item(ilpc_pkg::CMD_REPORT, ~CAPS_MASK, '0);
		push_item(ilpc_pkg::CMD_REPORT, '0, 7'd60);

		// zero-length touch hold, every-tick ramp, clamps at both ends
		push_reg(ilpc_pkg::REG_BOOT_LEVEL, 16'd100);
		push_reg(ilpc_pkg::REG_LEVEL_FLOOR, 16'd0);
		push_reg(ilpc_pkg::REG_ANIM_TOP, 16'd1);
		push_reg(ilpc_pkg::REG_ANIM_LOW, 16'd0);
		push_reg(ilpc_pkg::REG_ANIM_STEP, 16'd50);
		push_reg(ilpc_pkg::REG_ANIM_IVL, 16'd0);
		push_reg(ilpc_pkg::REG_BOOT_HOLD, 16'hFFFF);
		push_reg(ilpc_pkg::REG_TOUCH_HOLD, 16'd0);
		push_item(ilpc_pkg::CMD_TOUCH, '0, 7'd100);
		push_item(ilpc_pkg::CMD_TICK, '0, '0);
		push_item(ilpc_pkg::CMD_REPORT, CAPS_MASK, '0);
		push_item(ilpc_pkg::CMD_TICK, '0, '0);
		push_item(ilpc_pkg::CMD_TICK, '0, '0);
		push_item(ilpc_pkg::CMD_UNUSED, '0, '0);
		push_item(ilpc_pkg::CMD_REPORT, '0, '0);
		push_item(ilpc_pkg::CMD_TOUCH, '0, '0);
		push_item(ilpc_pkg::CMD_TICK, '0, '0);

		// short touch hold so touch holds expire while the boot hold still runs
		push_reg(ilpc_pkg::REG_BOOT_LEVEL, 16'd40);
		push_reg(ilpc_pkg::REG_LEVEL_FLOOR, 16'd10);
		push_reg(ilpc_pkg::REG_ANIM_TOP, 16'd90);
		push_reg(ilpc_pkg::REG_ANIM_LOW, 16'd20);
		push_reg(ilpc_pkg::REG_ANIM_STEP, 16'd7);
		push_reg(ilpc_pkg::REG_ANIM_IVL, 16'd3);
		push_reg(ilpc_pkg::REG_TOUCH_HOLD, 16'd5);
		for (int i = 0; i < BOOT_RUN_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 94)
				push_item(ilpc_pkg::CMD_TICK, ilpc_pkg::IND_W'($urandom_range(0, 255)),
					ilpc_pkg::LEVEL_W'($urandom_range(0, 127)));
			else
				push_random_item();
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				mode = SET_MIN;
			else if (p == 1)
				mode = SET_MAX;
			else if (p == PHASES - 1)
				mode = SET_WILD;
			else
				mode = SET_TYPICAL;
			for (int r = 0; r < NUM_REGS; r++) begin
				if (mode == SET_TYPICAL && $urandom_range(0, 5) == 0)
					push_reg(ilpc_pkg::IDX_W'(r),
						pick_reg_value(ilpc_pkg::IDX_W'(r), SET_WILD));
				else
					push_reg(ilpc_pkg::IDX_W'(r), pick_reg_value(ilpc_pkg::IDX_W'(r), mode));
			end
			drain_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == drain_at)
					push_drain();
				push_random_item();
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || in_valid || cfg_valid || pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (pending_levels.size() != 0) begin
			$error("led_level: %0d expected levels never arrived", pending_levels.size());
			fail_count++;
		end

		$display("Covered %0d input transactions (directed, tick run, %0d register phases)",
			items_sent, PHASES);
		$display("and %0d register writes; %0d LED levels checked, %0d failures",
			reg_writes, levels_checked, fail_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/ilpc_pkg.sv
hw/rtl/ilpc_cfg.sv
hw/rtl/ilpc_core.sv
hw/rtl/indicator_led_priority_controller_top.sv
tb/indicator_led_priority_controller_top_tb.sv
